>>> hdl/spherical_rotate_converter_assert.svh
// ============================================================================
// Assertion macros for the spherical rotate converter
// Concurrent checks on aclk; compiled out when SYNTHESIS is set.
// ============================================================================
`ifndef SPHERICAL_ROTATE_CONVERTER_ASSERT_SVH
`define SPHERICAL_ROTATE_CONVERTER_ASSERT_SVH

`ifndef SYNTHESIS
// check a property outside reset
`define SRCV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);
// check a property at every edge, reset included
`define SRCV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error(msg);
`else
`define SRCV_ASSERT(lbl, prop, msg)
`define SRCV_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> hdl/srcv_pkg.sv
// ============================================================================
// srcv_pkg
// Types, constants and angle helpers shared by the converter pipeline.
// ============================================================================
package srcv_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ANGLE_BITS    = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int IDX_W         = $clog2(ATAN_ENTRIES);

    // configuration register indexes
    localparam logic [1:0] REG_ROW0 = 2'd0;
    localparam logic [1:0] REG_ROW1 = 2'd1;
    localparam logic [1:0] REG_ROW2 = 2'd2;

    // vector datapath width and inner angle width
    localparam int VW = 40;
    localparam int AW = ((ANGLE_BITS > 16) ? ANGLE_BITS : 16) + 3;

    // inverse CORDIC gain, Q30
    localparam logic [29:0] INV_GAIN = 30'd652032874;

    // port angle (pi = 2^15) to inner angle (pi = 2^(ANGLE_BITS-1)) and back
    localparam int IN_UP   = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
    localparam int IN_DN   = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
    localparam int IN_RND  = (1 << IN_DN) >> 1;
    localparam int OUT_DN  = (ANGLE_BITS > 16) ? ANGLE_BITS - 16 : 0;
    localparam int OUT_UP  = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
    localparam int OUT_RND = (1 << OUT_DN) >> 1;

    typedef logic signed [VW-1:0] vec_t;
    typedef logic signed [AW-1:0] ang_t;
    typedef logic signed [18:0]   rect_t;

    localparam ang_t QUARTER = ang_t'(64'sd1 <<< (ANGLE_BITS - 2));

    // arctan(2^-i), full circle = 2^32
    localparam logic [31:0] ATAN_Q32 [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // per-cell control
    typedef struct packed {
        logic             vec_mode;
        logic             pre;
        logic [IDX_W-1:0] idx;
    } cell_cfg_t;

    // payload that rides along the pipeline
    typedef struct packed {
        ang_t  lon;
        vec_t  z;
        rect_t rx;
        rect_t ry;
        rect_t rz;
        logic  sat;
        logic  zero_h;
        ang_t  lon_acc;
        logic  zero_v;
        ang_t  lat_acc;
    } side_t;

    // arctangent of stage idx, rounded to the inner angle width
    function automatic ang_t step_angle(input logic [IDX_W-1:0] idx);
        logic [32:0] a;
        a = '0;
        if (int'(idx) < ATAN_ENTRIES) begin
            a = {1'b0, ATAN_Q32[idx]} + (33'd1 << (31 - ANGLE_BITS));
        end
        return ang_t'(a >> (32 - ANGLE_BITS));
    endfunction

    function automatic ang_t port_to_inner(input logic signed [16:0] v);
        ang_t w;
        w = ang_t'(v);
        return ((w + ang_t'(IN_RND)) >>> IN_DN) <<< IN_UP;
    endfunction

    function automatic ang_t inner_to_port(input ang_t v);
        return ((v + ang_t'(OUT_RND)) >>> OUT_DN) <<< OUT_UP;
    endfunction

endpackage

>>> hdl/srcv_cell.sv
// ============================================================================
// srcv_cell
// One CORDIC micro-rotation (or the quarter-turn pre-rotation), registered.
// ============================================================================
module srcv_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  srcv_pkg::cell_cfg_t   cfg,
    input  logic                  vld_in,
    input  srcv_pkg::vec_t        x_in,
    input  srcv_pkg::vec_t        y_in,
    input  srcv_pkg::ang_t        ang_in,
    input  srcv_pkg::side_t       side_in,
    output logic                  vld_out,
    output srcv_pkg::vec_t        x_out,
    output srcv_pkg::vec_t        y_out,
    output srcv_pkg::ang_t        ang_out,
    output srcv_pkg::side_t       side_out
);

    logic            vld_reg;
    srcv_pkg::vec_t  x_reg, y_reg, x_next, y_next, dx, dy;
    srcv_pkg::ang_t  ang_reg, ang_next, step;
    srcv_pkg::side_t side_reg;

    // turn the vector one step
    always_comb begin
        x_next   = x_in;
        y_next   = y_in;
        ang_next = ang_in;
        dx       = y_in >>> cfg.idx;
        dy       = x_in >>> cfg.idx;
        step     = srcv_pkg::step_angle(cfg.idx);
        if (cfg.pre) begin
            if (cfg.vec_mode) begin
                ang_next = '0;
                if (x_in < 0) begin
                    if (y_in >= 0) begin
                        x_next   = y_in;
                        y_next   = -x_in;
                        ang_next = srcv_pkg::QUARTER;
                    end else begin
                        x_next   = -y_in;
                        y_next   = x_in;
                        ang_next = -srcv_pkg::QUARTER;
                    end
                end
            end else begin
                if (ang_in > srcv_pkg::QUARTER) begin
                    x_next   = -y_in;
                    y_next   = x_in;
                    ang_next = ang_in - srcv_pkg::QUARTER;
                end else if (ang_in < -srcv_pkg::QUARTER) begin
                    x_next   = y_in;
                    y_next   = -x_in;
                    ang_next = ang_in + srcv_pkg::QUARTER;
                end
            end
        end else if (cfg.vec_mode) begin
            if (y_in >= 0) begin
                x_next   = x_in + dx;
                y_next   = y_in - dy;
                ang_next = ang_in + step;
            end else begin
                x_next   = x_in - dx;
                y_next   = y_in + dy;
                ang_next = ang_in - step;
            end
        end else begin
            if (ang_in >= 0) begin
                x_next   = x_in - dx;
                y_next   = y_in + dy;
                ang_next = ang_in - step;
            end else begin
                x_next   = x_in + dx;
                y_next   = y_in - dy;
                ang_next = ang_in + step;
            end
        end
    end

    // advance on enable
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            ang_reg  <= ang_next;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign ang_out  = ang_reg;
    assign side_out = side_reg;

endmodule

>>> hdl/srcv_cordic.sv
// ============================================================================
// srcv_cordic
// Chain of cells: one quarter-turn cell, then one cell per CORDIC stage.
// ============================================================================
module srcv_cordic (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            vec_mode,
    input  logic            vld_in,
    input  srcv_pkg::vec_t  x_in,
    input  srcv_pkg::vec_t  y_in,
    input  srcv_pkg::ang_t  ang_in,
    input  srcv_pkg::side_t side_in,
    output logic            vld_out,
    output srcv_pkg::vec_t  x_out,
    output srcv_pkg::vec_t  y_out,
    output srcv_pkg::ang_t  ang_out,
    output srcv_pkg::side_t side_out
);

    localparam int N = srcv_pkg::CORDIC_STAGES + 1;

    logic            vld_c  [N+1];
    srcv_pkg::vec_t  x_c    [N+1];
    srcv_pkg::vec_t  y_c    [N+1];
    srcv_pkg::ang_t  ang_c  [N+1];
    srcv_pkg::side_t side_c [N+1];

    assign vld_c[0]  = vld_in;
    assign x_c[0]    = x_in;
    assign y_c[0]    = y_in;
    assign ang_c[0]  = ang_in;
    assign side_c[0] = side_in;

    // build the row of cells
    for (genvar k = 0; k < N; k++) begin : g_cell
        srcv_pkg::cell_cfg_t ccfg;
        assign ccfg.vec_mode = vec_mode;
        assign ccfg.pre      = (k == 0);
        assign ccfg.idx      = srcv_pkg::IDX_W'((k == 0) ? 0 : k - 1);

        srcv_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .cfg      (ccfg),
            .vld_in   (vld_c[k]),
            .x_in     (x_c[k]),
            .y_in     (y_c[k]),
            .ang_in   (ang_c[k]),
            .side_in  (side_c[k]),
            .vld_out  (vld_c[k+1]),
            .x_out    (x_c[k+1]),
            .y_out    (y_c[k+1]),
            .ang_out  (ang_c[k+1]),
            .side_out (side_c[k+1])
        );
    end

    assign vld_out  = vld_c[N];
    assign x_out    = x_c[N];
    assign y_out    = y_c[N];
    assign ang_out  = ang_c[N];
    assign side_out = side_c[N];

endmodule

>>> hdl/srcv_unscale.sv
// ============================================================================
// srcv_unscale
// Two-stage multiply by the inverse CORDIC gain, offset by 2^14, shifted down by 30.
// ============================================================================
module srcv_unscale (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            vld_in,
    input  srcv_pkg::vec_t  v_in,
    input  srcv_pkg::side_t side_in,
    output logic            vld_out,
    output srcv_pkg::vec_t  v_out,
    output srcv_pkg::side_t side_out
);

    localparam int LO_W = 20;
    localparam int HI_W = srcv_pkg::VW - LO_W;
    localparam int SUMW = srcv_pkg::VW + 31;

    typedef logic signed [SUMW-1:0] sum_t;

    logic                     vld1_reg, vld2_reg;
    logic signed [HI_W+30:0]  p_hi_reg, p_hi_next;
    logic [LO_W+29:0]         p_lo_reg, p_lo_next;
    srcv_pkg::side_t          side1_reg, side2_reg;
    srcv_pkg::vec_t           v_reg;
    sum_t                     sum;

    // split into two partial products
    always_comb begin
        p_hi_next = $signed(v_in[srcv_pkg::VW-1:LO_W]) * $signed({1'b0, srcv_pkg::INV_GAIN});
        p_lo_next = v_in[LO_W-1:0] * srcv_pkg::INV_GAIN;
    end

    // recombine, add the 2^14 offset
    always_comb begin
        sum = (sum_t'(p_hi_reg) <<< LO_W) + sum_t'($signed({1'b0, p_lo_reg}))
            + sum_t'(16384);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= vld_in;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_hi_reg  <= p_hi_next;
            p_lo_reg  <= p_lo_next;
            side1_reg <= side_in;
            v_reg     <= srcv_pkg::vec_t'(sum >>> 30);
            side2_reg <= side1_reg;
        end
    end

    assign vld_out  = vld2_reg;
    assign v_out    = v_reg;
    assign side_out = side2_reg;

endmodule

>>> hdl/spherical_rotate_converter.sv
// ============================================================================
// spherical_rotate_converter
// Polar to rectangular, 3x3 rotation, rectangular back to polar.
//
//   channel   ports                  beat carries
//   cfg       cfg_wr_en/addr/wdata   one matrix row, three Q1.14 coefficients
//   s_        s_valid / s_ready      latitude, longitude, range
//   m_        m_valid / m_ready      rotated x, y, z, latitude, longitude, range
//
// One beat enters per cycle unless m_ready stalls it; the path is 4 CORDIC
// chains of 17 cells, 3 unscale pairs, 3 matrix stages and 3 more registers.
// The whole pipeline advances together; it holds while m_valid waits on
// m_ready, and s_ready drops only then. Reset clears valid bits and loads
// the identity matrix.
// ============================================================================
module spherical_rotate_converter (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_addr,
    input  logic [47:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_latitude_in,
    input  logic signed [16:0] s_longitude_in,
    input  logic [15:0]        s_radius_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [18:0] m_rect_x,
    output logic signed [18:0] m_rect_y,
    output logic signed [18:0] m_rect_z,
    output logic signed [15:0] m_latitude_out,
    output logic signed [15:0] m_longitude_out,
    output logic [17:0]        m_radius_out,
    output logic               m_saturated
);

`include "spherical_rotate_converter_assert.svh"

    typedef logic signed [49:0] mprod_t;
    typedef logic signed [51:0] msum_t;

    logic en;
    logic [47:0] row_reg [3];

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg[0] <= 48'h0000_0000_4000;
            row_reg[1] <= 48'h0000_4000_0000;
            row_reg[2] <= 48'h4000_0000_0000;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                srcv_pkg::REG_ROW0: row_reg[0] <= cfg_wdata;
                srcv_pkg::REG_ROW1: row_reg[1] <= cfg_wdata;
                srcv_pkg::REG_ROW2: row_reg[2] <= cfg_wdata;
                default:  ;
            endcase
        end
    end

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // ---------------- input stage: wrap longitude ----------------
    logic signed [17:0] lon18;
    logic               p0_vld_reg, p1_vld_reg;
    srcv_pkg::ang_t     lat0_reg, lon0_reg, lat1_reg;
    logic [15:0]        r0_reg;
    srcv_pkg::vec_t     x1_reg;
    srcv_pkg::side_t    side1_reg, side1_next;
    logic [45:0]        r_prod;

    always_comb begin
        lon18 = 18'(s_longitude_in);
        if (lon18 > 18'sd32768) begin
            lon18 = lon18 - 18'sd65536;
        end else if (lon18 < -18'sd32768) begin
            lon18 = lon18 + 18'sd65536;
        end
    end

    // scale the range by the inverse gain
    always_comb begin
        r_prod         = r0_reg * srcv_pkg::INV_GAIN;
        side1_next     = '0;
        side1_next.lon = lon0_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_vld_reg <= 1'b0;
            p1_vld_reg <= 1'b0;
        end else if (en) begin
            p0_vld_reg <= s_valid;
            p1_vld_reg <= p0_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lat0_reg  <= srcv_pkg::port_to_inner(17'(s_latitude_in));
            lon0_reg  <= srcv_pkg::port_to_inner(lon18[16:0]);
            r0_reg    <= s_radius_in;
            x1_reg    <= srcv_pkg::vec_t'(r_prod >> 14);
            lat1_reg  <= lat0_reg;
            side1_reg <= side1_next;
        end
    end

    // ---------------- latitude rotation ----------------
    logic            c1_vld;
    srcv_pkg::vec_t  c1_x, c1_y;
    srcv_pkg::ang_t  c1_ang;
    srcv_pkg::side_t c1_side, u1_side_in;

    srcv_cordic u_rot_lat (
        .aclk (aclk), .aresetn (aresetn), .en (en), .vec_mode (1'b0),
        .vld_in (p1_vld_reg), .x_in (x1_reg), .y_in ('0), .ang_in (lat1_reg),
        .side_in (side1_reg),
        .vld_out (c1_vld), .x_out (c1_x), .y_out (c1_y), .ang_out (c1_ang),
        .side_out (c1_side)
    );

    // keep z, unscale the horizontal part
    always_comb begin
        u1_side_in   = c1_side;
        u1_side_in.z = c1_y;
    end

    logic            u1_vld;
    srcv_pkg::vec_t  u1_v;
    srcv_pkg::side_t u1_side;

    srcv_unscale u_un_h (
        .aclk (aclk), .aresetn (aresetn), .en (en), .vld_in (c1_vld), .v_in (c1_x),
        .side_in (u1_side_in), .vld_out (u1_vld), .v_out (u1_v), .side_out (u1_side)
    );

    // ---------------- longitude rotation ----------------
    logic            c2_vld;
    srcv_pkg::vec_t  c2_x, c2_y;
    srcv_pkg::ang_t  c2_ang;
    srcv_pkg::side_t c2_side;

    srcv_cordic u_rot_lon (
        .aclk (aclk), .aresetn (aresetn), .en (en), .vec_mode (1'b0),
        .vld_in (u1_vld), .x_in (u1_v), .y_in ('0), .ang_in (u1_side.lon),
        .side_in (u1_side),
        .vld_out (c2_vld), .x_out (c2_x), .y_out (c2_y), .ang_out (c2_ang),
        .side_out (c2_side)
    );

    // ---------------- matrix ----------------
    srcv_pkg::vec_t  vin [3];
    mprod_t          mp_next [3][3];
    mprod_t          mp_reg  [3][3];
    srcv_pkg::vec_t  rot_next [3];
    srcv_pkg::vec_t  rot_reg  [3];
    srcv_pkg::vec_t  rnd  [3];
    srcv_pkg::rect_t rect [3];
    msum_t           msum [3];
    logic [2:0]      rsat;
    logic            m1_vld_reg, m2_vld_reg, m3_vld_reg;
    srcv_pkg::side_t m1_side_reg, m2_side_reg, m3_side_reg, m3_side_next;
    srcv_pkg::vec_t  m3_x_reg, m3_y_reg;

    // form the nine products
    always_comb begin
        vin[0] = c2_x;
        vin[1] = c2_y;
        vin[2] = c2_side.z;
        for (int k = 0; k < 3; k++) begin
            for (int c = 0; c < 3; c++) begin
                mp_next[k][c] = $signed(row_reg[k][16*c +: 16]) * $signed(vin[c][33:0]);
            end
        end
    end

    // sum each row, round off Q14
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            msum[k] = msum_t'(mp_reg[k][0]) + msum_t'(mp_reg[k][1])
                    + msum_t'(mp_reg[k][2]) + msum_t'(8192);
            rot_next[k] = srcv_pkg::vec_t'(msum[k] >>> 14);
        end
    end

    // round to coordinate units and clip
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rnd[k]  = (rot_reg[k] + srcv_pkg::vec_t'(32768)) >>> 16;
            rsat[k] = 1'b0;
            rect[k] = rnd[k][18:0];
            if (rnd[k] < -262144) begin
                rect[k] = -19'sd262144;
                rsat[k] = 1'b1;
            end else if (rnd[k] > 262143) begin
                rect[k] = 19'sd262143;
                rsat[k] = 1'b1;
            end
        end
        m3_side_next        = m2_side_reg;
        m3_side_next.z      = rot_reg[2];
        m3_side_next.rx     = rect[0];
        m3_side_next.ry     = rect[1];
        m3_side_next.rz     = rect[2];
        m3_side_next.sat    = |rsat;
        m3_side_next.zero_h = (rot_reg[0] == '0) && (rot_reg[1] == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
            m3_vld_reg <= 1'b0;
        end else if (en) begin
            m1_vld_reg <= c2_vld;
            m2_vld_reg <= m1_vld_reg;
            m3_vld_reg <= m2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mp_reg      <= mp_next;
            m1_side_reg <= c2_side;
            rot_reg     <= rot_next;
            m2_side_reg <= m1_side_reg;
            m3_x_reg    <= rot_reg[0];
            m3_y_reg    <= rot_reg[1];
            m3_side_reg <= m3_side_next;
        end
    end

    // ---------------- longitude vectoring ----------------
    logic            c3_vld;
    srcv_pkg::vec_t  c3_x, c3_y;
    srcv_pkg::ang_t  c3_ang;
    srcv_pkg::side_t c3_side, u2_side_in;

    srcv_cordic u_vec_lon (
        .aclk (aclk), .aresetn (aresetn), .en (en), .vec_mode (1'b1),
        .vld_in (m3_vld_reg), .x_in (m3_x_reg), .y_in (m3_y_reg), .ang_in ('0),
        .side_in (m3_side_reg),
        .vld_out (c3_vld), .x_out (c3_x), .y_out (c3_y), .ang_out (c3_ang),
        .side_out (c3_side)
    );

    // drop the angle of a zero horizontal part
    always_comb begin
        u2_side_in         = c3_side;
        u2_side_in.lon_acc = c3_side.zero_h ? '0 : c3_ang;
    end

    logic            u2_vld;
    srcv_pkg::vec_t  u2_v;
    srcv_pkg::side_t u2_side, c4_side_in;

    srcv_unscale u_un_hv (
        .aclk (aclk), .aresetn (aresetn), .en (en), .vld_in (c3_vld), .v_in (c3_x),
        .side_in (u2_side_in), .vld_out (u2_vld), .v_out (u2_v), .side_out (u2_side)
    );

    // ---------------- latitude vectoring ----------------
    always_comb begin
        c4_side_in        = u2_side;
        c4_side_in.zero_v = (u2_v == '0) && (u2_side.z == '0);
    end

    logic            c4_vld;
    srcv_pkg::vec_t  c4_x, c4_y;
    srcv_pkg::ang_t  c4_ang;
    srcv_pkg::side_t c4_side, u3_side_in;

    srcv_cordic u_vec_lat (
        .aclk (aclk), .aresetn (aresetn), .en (en), .vec_mode (1'b1),
        .vld_in (u2_vld), .x_in (u2_v), .y_in (u2_side.z), .ang_in ('0),
        .side_in (c4_side_in),
        .vld_out (c4_vld), .x_out (c4_x), .y_out (c4_y), .ang_out (c4_ang),
        .side_out (c4_side)
    );

    always_comb begin
        u3_side_in         = c4_side;
        u3_side_in.lat_acc = c4_side.zero_v ? '0 : c4_ang;
    end

    logic            u3_vld;
    srcv_pkg::vec_t  u3_v;
    srcv_pkg::side_t u3_side;

    srcv_unscale u_un_mag (
        .aclk (aclk), .aresetn (aresetn), .en (en), .vld_in (c4_vld), .v_in (c4_x),
        .side_in (u3_side_in), .vld_out (u3_vld), .v_out (u3_v), .side_out (u3_side)
    );

    // ---------------- output register ----------------
    logic               out_vld_reg;
    srcv_pkg::rect_t    rx_reg, ry_reg, rz_reg;
    logic signed [15:0] lat_reg, lat_next, lon_reg;
    logic [17:0]        rad_reg, rad_next;
    logic               sat_reg, sat_next;
    srcv_pkg::ang_t     lat_p, lon_p;
    srcv_pkg::vec_t     rad_r;

    // convert angles to port scale, clip the latitude, round and clip the range
    always_comb begin
        lat_p    = srcv_pkg::inner_to_port(u3_side.lat_acc);
        lon_p    = srcv_pkg::inner_to_port(u3_side.lon_acc);
        lat_next = lat_p[15:0];
        if (lat_p > 16384) begin
            lat_next = 16'sd16384;
        end else if (lat_p < -16384) begin
            lat_next = -16'sd16384;
        end
        rad_r    = (u3_v + srcv_pkg::vec_t'(32768)) >>> 16;
        rad_next = rad_r[17:0];
        sat_next = u3_side.sat;
        if (rad_r < 0) begin
            rad_next = '0;
            sat_next = 1'b1;
        end else if (rad_r > 262143) begin
            rad_next = 18'd262143;
            sat_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= u3_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rx_reg  <= u3_side.rx;
            ry_reg  <= u3_side.ry;
            rz_reg  <= u3_side.rz;
            lat_reg <= lat_next;
            lon_reg <= lon_p[15:0];
            rad_reg <= rad_next;
            sat_reg <= sat_next;
        end
    end

    assign m_valid         = out_vld_reg;
    assign m_rect_x        = rx_reg;
    assign m_rect_y        = ry_reg;
    assign m_rect_z        = rz_reg;
    assign m_latitude_out  = lat_reg;
    assign m_longitude_out = lon_reg;
    assign m_radius_out    = rad_reg;
    assign m_saturated     = sat_reg;

    // ---------------- assertions ----------------
    logic lat_ok;
    assign lat_ok = (m_latitude_out <= 16'sd16384) && (m_latitude_out >= -16'sd16384);

    `SRCV_ASSERT_ALWAYS(a_rst_clears_out, !aresetn |=> !m_valid, "output valid after reset")
    `SRCV_ASSERT(a_accept_enters, s_valid && s_ready |=> p0_vld_reg, "accepted beat lost")
    `SRCV_ASSERT(a_stall_blocks_in, m_valid && !m_ready |-> !s_ready, "input taken in stall")
    `SRCV_ASSERT(a_lat_range, m_valid |-> lat_ok, "latitude out of range")

endmodule
